FILE: src/svbe_pkg.sv
// Shared constants, types and helper functions of the signed varint byte encoder.
package svbe_pkg;

  localparam int MaxBytes = 6;
  localparam int ByteW    = 7;
  localparam int CountW   = 3;
  localparam int GroupW   = 6;
  localparam int LowW     = 2;
  localparam int ValueW   = 32;

  localparam logic [ByteW-1:0] GroupOffset = 7'd64;

  typedef struct packed {
    logic [CountW-1:0]                count;
    logic [MaxBytes-1:0][ByteW-1:0]   bytes;
  } enc_t;

  // Total byte count: the header plus every group up to the highest non-zero one.
  function automatic logic [CountW-1:0] byte_count(input logic [ValueW-1:0] mag);
    logic [CountW-1:0] cnt;
    cnt = CountW'(1);
    for (int g = 1; g < MaxBytes; g++) begin
      if (mag[LowW + GroupW * (g - 1) +: GroupW] != '0) begin
        cnt = CountW'(g + 1);
      end
    end
    return cnt;
  endfunction

endpackage

FILE: src/signed_varint_byte_encoder_unit.sv
// Top level of the signed varint byte encoder: input pipeline, encoder and serialiser.
// Each accepted item yields one to six bytes, one per clock cycle, with last_o set on the
// final byte; a value whose magnitude fits in n bits beyond the two header bits takes
// 1 + ceil(n / 6) bytes. The item is registered in value1_q, mag2_q and enc3_q in turn before
// the serialiser loads it and puts its first byte on the outputs. The serialiser sends one
// byte per cycle, so the sustained item rate is set by the byte count of each item; up to
// three further items wait in the pipeline and busy rises when it is full. Results carry
// no back-pressure: each byte is on out_byte_o for exactly the one cycle in which strobe_o
// is high.
module signed_varint_byte_encoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [svbe_pkg::ValueW-1:0] value_i,
  output logic                              strobe_o,
  output logic [svbe_pkg::ByteW-1:0]        out_byte_o,
  output logic                              last_o
);
  import svbe_pkg::*;

  logic              v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic [ValueW-1:0] value1_q;
  logic [ValueW-1:0] mag2_q, mag2_d;
  logic              neg2_q;
  enc_t              enc3_q, enc3_d;
  logic              free1, free2, free3;
  logic              ser_ready;
  logic              ser_load;

  assign free3    = !v3_q || ser_ready;
  assign free2    = !v2_q || free3;
  assign free1    = !v1_q || free2;
  assign busy     = !free1;
  assign ser_load = v3_q && ser_ready;

  assign v1_d = free1 ? start : v1_q;
  assign v2_d = free2 ? v1_q : v2_q;
  assign v3_d = free3 ? v2_q : v3_q;

  assign mag2_d = value1_q[ValueW-1] ? (ValueW'(0) - value1_q) : value1_q;

  always_comb begin
    enc3_d.count    = byte_count(mag2_q);
    enc3_d.bytes[0] = {1'b1, enc3_d.count, neg2_q, mag2_q[LowW-1:0]};
    for (int k = 1; k < MaxBytes; k++) begin
      enc3_d.bytes[k] = GroupOffset | ByteW'(mag2_q[LowW + GroupW * (k - 1) +: GroupW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && free1) begin
      value1_q <= value_i;
    end
    if (v1_q && free2) begin
      mag2_q <= mag2_d;
      neg2_q <= value1_q[ValueW-1];
    end
    if (v2_q && free3) begin
      enc3_q <= enc3_d;
    end
  end

  svbe_serializer u_serializer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ser_load),
    .enc_i    (enc3_q),
    .ready_o  (ser_ready),
    .strobe_o (strobe_o),
    .byte_o   (out_byte_o),
    .last_o   (last_o)
  );

`ifndef SYNTHESIS
  // The pipeline only pushes back when every stage holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> (v1_q && v2_q && v3_q))
    else $error("busy raised while a pipeline stage is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni) last_o |-> strobe_o)
    else $error("last byte marked without a strobe");

  // The bytes of one item leave in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside the bytes of one item");

  // A new item is only loaded into the serialiser once the previous one is finishing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (ser_load && strobe_o) |-> last_o)
    else $error("serialiser reloaded before the last byte");
`endif

endmodule

FILE: src/svbe_serializer.sv
// Output serialiser: holds one encoded item and sends its bytes one per cycle.
module svbe_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  svbe_pkg::enc_t                  enc_i,
  output logic                            ready_o,
  output logic                            strobe_o,
  output logic [svbe_pkg::ByteW-1:0]      byte_o,
  output logic                            last_o
);
  import svbe_pkg::*;

  logic [CountW-1:0]              rem_q, rem_d;
  logic [MaxBytes-1:0][ByteW-1:0] bytes_q, bytes_d;

  always_comb begin
    rem_d   = rem_q;
    bytes_d = bytes_q;
    if (load_i) begin
      rem_d   = enc_i.count;
      bytes_d = enc_i.bytes;
    end else if (rem_q != '0) begin
      rem_d   = rem_q - CountW'(1);
      bytes_d = {ByteW'(0), bytes_q[MaxBytes-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign ready_o  = (rem_q == '0) || (rem_q == CountW'(1));
  assign strobe_o = (rem_q != '0);
  assign byte_o   = bytes_q[0];
  assign last_o   = (rem_q == CountW'(1));

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the signed varint byte encoder unit.
module tb;
  import svbe_pkg::*;

  localparam int SignBit  = 2;
  localparam int CountLsb = 3;

  typedef struct {
    logic signed [ValueW-1:0] source;
    logic [ByteW-1:0]         code;
    logic                     is_last;
  } enc_byte_t;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     start   = 1'b0;
  logic                     busy;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     strobe_o;
  logic [ByteW-1:0]         out_byte_o;
  logic                     last_o;

  logic signed [ValueW-1:0] pending_values[$];
  enc_byte_t                expected_bytes[$];
  int                       mismatch_count = 0;
  int                       burst_left     = 1;
  int                       gap_left       = 0;

  signed_varint_byte_encoder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void predict_encoding(input logic signed [ValueW-1:0] v);
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] rest;
    logic [ByteW-1:0]  codes[MaxBytes];
    logic [CountW-1:0] cnt_bits;
    enc_byte_t         entry;
    int                cnt;
    mag      = v[ValueW-1] ? (~v + 1'b1) : v;
    codes[0] = GroupOffset + ByteW'(mag[LowW-1:0]);
    cnt      = 1;
    rest     = mag >> LowW;
    while (rest != '0 && cnt < MaxBytes) begin
      codes[cnt] = GroupOffset + ByteW'(rest[GroupW-1:0]);
      cnt++;
      rest = rest >> GroupW;
    end
    cnt_bits = CountW'(cnt);
    codes[0][CountLsb +: CountW] = cnt_bits;
    codes[0][SignBit]            = v[ValueW-1];
    for (int k = 0; k < cnt; k++) begin
      entry.source  = v;
      entry.code    = codes[k];
      entry.is_last = (k == cnt - 1);
      expected_bytes.insert(expected_bytes.size(), entry);
    end
  endfunction

  // Items are sent in bursts; a new gap is drawn whenever a burst runs out.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      value_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_encoding(value_i);
        void'(pending_values.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (gap_left > 0 || pending_values.size() == 0) begin
          start <= 1'b0;
        end else begin
          value_i <= pending_values[0];
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_values.size() != 0) begin
          start   <= 1'b1;
          value_i <= pending_values[0];
        end
      end
    end
  end

  always @(posedge clk_i) begin
    enc_byte_t exp_byte;
    if (rst_ni && strobe_o) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual code %0d last %0b",
                 $time, out_byte_o, last_o);
        mismatch_count++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (out_byte_o !== exp_byte.code) begin
          $display("%0t: value %0d: code expected %0d, actual %0d",
                   $time, exp_byte.source, exp_byte.code, out_byte_o);
          mismatch_count++;
        end
        if (last_o !== exp_byte.is_last) begin
          $display("%0t: value %0d: last expected %0b, actual %0b",
                   $time, exp_byte.source, exp_byte.is_last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic signed [ValueW-1:0] boundaries[$];
    logic [ValueW-1:0]        raw;
    int                       width;
    boundaries = '{0, 1, -1, 3, 4, -4, 255, 256, -256, 16383, 16384, -16384,
                   (1 << 20) - 1, 1 << 20, -(1 << 20), (1 << 26) - 1, 1 << 26,
                   -(1 << 26), 32'sh7fffffff, 32'sh80000000, 32'sh80000001,
                   32'sh55555555, 32'shaaaaaaaa};
    foreach (boundaries[i]) pending_values.insert(pending_values.size(), boundaries[i]);
    // Random part: half full-width values, half values of a random magnitude width
    // so that every byte count turns up often.
    for (int i = 0; i < 237; i++) begin
      raw = $urandom;
      if ($urandom_range(0, 1) == 1) begin
        width = $urandom_range(0, ValueW - 1);
        raw   = raw & ((ValueW'(1) << width) - 1'b1);
        if ($urandom_range(0, 1) == 1) raw = ~raw + 1'b1;
      end
      pending_values.insert(pending_values.size(), raw);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_values.size() != 0 || start) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
src/svbe_pkg.sv
src/svbe_serializer.sv
src/signed_varint_byte_encoder_unit.sv
tb/tb.sv
